@@ rtl/decimal_text_to_fixed_e4_top_defines.svh @@
// Assertion macros for the decimal text to fixed point block.
// Used by the port checker; no other dependencies.
`ifndef DECIMAL_TEXT_TO_FIXED_E4_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_E4_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTFE4_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTFE4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dtfe4_pkg.sv @@
// Shared types, constants and arithmetic helpers of the decimal text parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package dtfe4_pkg;

    // Number of fraction digits in the fixed-point format (scale 10^4).
    localparam int FRAC_PLACES     = 4;
    // Default depth of the token queue between front and back.
    localparam int DEF_QUEUE_DEPTH = 2;
    // Magnitude width: values up to 2^63-1.
    localparam int ACC_W           = 63;
    // Width of acc*10+digit before the range check.
    localparam int PROD_W          = ACC_W + 4;
    // Width of a fraction digit count or pad count.
    localparam int PAD_W           = $clog2(FRAC_PLACES + 1);

    // Character codes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // Character classes found by the front part.
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_DIGIT,
        CLS_MINUS,
        CLS_DOT,
        CLS_OTHER
    } tok_class_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // One classified character word.
    typedef struct packed {
        tok_class_t cls;
        logic [3:0] digit;
        logic       last;
    } token_t;

    // A finished text on its way through the scaling pipeline.
    typedef struct packed {
        status_t            status;
        logic               neg;
        logic [ACC_W-1:0]   acc;
        logic [PAD_W-1:0]   pad;
    } fin_t;

    // acc*10 + d as a shift-add, wide enough to see any overflow.
    function automatic logic [PROD_W-1:0] times_ten_plus(input logic [ACC_W-1:0] acc,
                                                         input logic [3:0] d);
        logic [PROD_W-1:0] wide;
        wide = {{(PROD_W-ACC_W){1'b0}}, acc};
        return (wide << 3) + (wide << 1) + {{(PROD_W-4){1'b0}}, d};
    endfunction

    // True when a product no longer fits in 2^63-1.
    function automatic logic too_wide(input logic [PROD_W-1:0] prod);
        return prod[PROD_W-1:ACC_W] != '0;
    endfunction

endpackage

`default_nettype wire

@@ rtl/dtfe4_front.sv @@
// Front part: classifies each input character and registers it as a token word.
// Depends on dtfe4_pkg.
`default_nettype none

module dtfe4_front
    import dtfe4_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_character,
    input  wire logic       s_last_char,
    input  wire logic       s_no_character,
    output logic            tok_valid,
    input  wire logic       tok_ready,
    output token_t          tok
);

    logic       valid_reg;
    logic       valid_next;
    token_t     tok_reg;
    token_t     tok_next;
    logic [7:0] char_off;
    logic       load;

    // Classify the incoming character.
    always_comb begin
        char_off      = s_character - CHAR_ZERO;
        tok_next.last = s_last_char;
        tok_next.digit = char_off[3:0];
        if (s_no_character) begin
            tok_next.cls = CLS_NONE;
        end else if (s_character inside {[CHAR_ZERO:CHAR_NINE]}) begin
            tok_next.cls = CLS_DIGIT;
        end else if (s_character == CHAR_MINUS) begin
            tok_next.cls = CLS_MINUS;
        end else if (s_character == CHAR_DOT) begin
            tok_next.cls = CLS_DOT;
        end else begin
            tok_next.cls = CLS_OTHER;
        end
    end

    // The register takes a new word whenever it is empty or being drained.
    assign s_ready    = !valid_reg || tok_ready;
    assign load       = s_valid && s_ready;
    assign valid_next = load || (valid_reg && !tok_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

endmodule

`default_nettype wire

@@ rtl/dtfe4_queue.sv @@
// Short token queue that decouples the front part from the parser.
// Depends on dtfe4_pkg.
`default_nettype none

module dtfe4_queue
    import dtfe4_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire token_t in_tok,
    output logic        out_valid,
    input  wire logic   out_ready,
    output token_t      out_tok
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer wrap and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_tok;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dtfe4_parse.sv @@
// Back part: runs the grammar over token words and accumulates the digits.
// Depends on dtfe4_pkg.
`default_nettype none

module dtfe4_parse
    import dtfe4_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   tok_valid,
    output logic        tok_ready,
    input  wire token_t tok,
    output logic        fin_valid,
    input  wire logic   fin_ready,
    output fin_t        fin
);

    typedef enum logic [1:0] {
        PH_START,
        PH_WHOLE,
        PH_FRAC
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               seen_reg, seen_next;
    logic               too_big_reg, too_big_next;
    logic               ovf_reg, ovf_next;
    logic [PAD_W-1:0]   fcount_reg, fcount_next;
    logic               malformed_reg, malformed_next;
    logic [PROD_W-1:0]  prod;
    logic               fire;

    // A last word needs room downstream; others are always taken.
    assign tok_ready = !tok.last || fin_ready;
    assign fire      = tok_valid && tok_ready;
    assign fin_valid = tok_valid && tok.last;

    // Whole and fraction digits share one accumulator, so it ends as
    // whole*10^k plus the fraction prefix.
    assign prod = times_ten_plus(acc_reg, tok.digit);

    // Grammar step for one word.
    always_comb begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        too_big_next   = too_big_reg;
        ovf_next       = ovf_reg;
        fcount_next    = fcount_reg;
        malformed_next = malformed_reg;
        if (!malformed_reg && tok.cls != CLS_NONE) begin
            if (phase_reg == PH_FRAC) begin
                if (tok.cls == CLS_DIGIT && fcount_reg < PAD_W'(FRAC_PLACES)) begin
                    if (!ovf_reg) begin
                        if (too_wide(prod)) begin
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = prod[ACC_W-1:0];
                        end
                    end
                    fcount_next = fcount_reg + 1'b1;
                end else begin
                    malformed_next = 1'b1;
                end
            end else begin
                if (tok.cls == CLS_DIGIT) begin
                    if (!too_big_reg) begin
                        if (too_wide(prod)) begin
                            too_big_next = 1'b1;
                        end else begin
                            acc_next = prod[ACC_W-1:0];
                        end
                    end
                    seen_next  = 1'b1;
                    phase_next = PH_WHOLE;
                end else if (tok.cls == CLS_MINUS && phase_reg == PH_START) begin
                    neg_next   = 1'b1;
                    phase_next = PH_WHOLE;
                end else if (tok.cls == CLS_DOT && seen_reg) begin
                    phase_next = PH_FRAC;
                end else begin
                    malformed_next = 1'b1;
                end
            end
        end
    end

    // Finished text record, built from the state after this word.
    always_comb begin
        fin.neg = neg_next;
        fin.acc = acc_next;
        fin.pad = PAD_W'(FRAC_PLACES) - fcount_next;
        if (malformed_next || !seen_next || too_big_next ||
            (phase_next == PH_FRAC && fcount_next == '0)) begin
            fin.status = ST_MALFORMED;
        end else if (ovf_next) begin
            fin.status = ST_OVERFLOW;
        end else begin
            fin.status = ST_OK;
        end
    end

    // Parser state; a last word returns everything to the start.
    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && tok.last)) begin
            phase_reg     <= PH_START;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            too_big_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            fcount_reg    <= '0;
            malformed_reg <= 1'b0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            too_big_reg   <= too_big_next;
            ovf_reg       <= ovf_next;
            fcount_reg    <= fcount_next;
            malformed_reg <= malformed_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dtfe4_finish.sv @@
// Finishing pipeline: pads the fraction by steps of ten, applies the sign and
// holds the result word. Depends on dtfe4_pkg.
`default_nettype none

module dtfe4_finish
    import dtfe4_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         fin_valid,
    output logic              fin_ready,
    input  wire fin_t         fin,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic signed [63:0] m_fixed_value,
    output logic [1:0]        m_status
);

    localparam int NSTAGE = FRAC_PLACES;

    fin_t               stg_reg       [NSTAGE];
    logic               stg_valid_reg [NSTAGE];
    fin_t               stg_in        [NSTAGE];
    logic               stg_in_valid  [NSTAGE];
    logic               rdy           [NSTAGE+1];
    logic               m_valid_reg;
    logic signed [63:0] m_fixed_value_reg;
    logic signed [63:0] m_fixed_value_next;
    logic [1:0]         m_status_reg;
    fin_t               tail;
    logic [63:0]        magnitude;

    // One padding step: multiply by ten while digits are missing.
    function automatic fin_t scale_step(input fin_t f);
        fin_t              r;
        logic [PROD_W-1:0] p;
        r = f;
        p = times_ten_plus(f.acc, 4'd0);
        if (f.status == ST_OK && f.pad != '0) begin
            if (too_wide(p)) begin
                r.status = ST_OVERFLOW;
            end
            r.acc = p[ACC_W-1:0];
            r.pad = f.pad - 1'b1;
        end
        return r;
    endfunction

    assign rdy[NSTAGE] = !m_valid_reg || m_ready;
    assign fin_ready   = rdy[0];

    // Padding stages, each one shift-add with its own register.
    for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign stg_in[g]       = fin;
            assign stg_in_valid[g] = fin_valid;
        end else begin : g_rest
            assign stg_in[g]       = stg_reg[g-1];
            assign stg_in_valid[g] = stg_valid_reg[g-1];
        end

        assign rdy[g] = !stg_valid_reg[g] || rdy[g+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_valid_reg[g] <= 1'b0;
            end else if (rdy[g]) begin
                stg_valid_reg[g] <= stg_in_valid[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[g]) begin
                stg_reg[g] <= scale_step(stg_in[g]);
            end
        end
    end

    // Sign and status gating for the result word.
    assign tail      = stg_reg[NSTAGE-1];
    assign magnitude = {1'b0, tail.acc};

    always_comb begin
        if (tail.status != ST_OK) begin
            m_fixed_value_next = '0;
        end else if (tail.neg) begin
            m_fixed_value_next = -$signed(magnitude);
        end else begin
            m_fixed_value_next = $signed(magnitude);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy[NSTAGE]) begin
            m_valid_reg <= stg_valid_reg[NSTAGE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NSTAGE]) begin
            m_fixed_value_reg <= m_fixed_value_next;
            m_status_reg      <= tail.status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_fixed_value = m_fixed_value_reg;
    assign m_status      = m_status_reg;

endmodule

`default_nettype wire

@@ rtl/decimal_text_to_fixed_e4_top.sv @@
// Decimal text to fixed point (scale 10000), one character word per cycle.
// The block takes one character per clock cycle without gaps as long as the
// result side keeps up. The word carrying last_char passes the front register,
// the token queue, four padding stages that multiply by ten by shift-add, the
// first of which also takes the parser step, and the output register before
// m_valid rises. The sustained rate is set by the parser, which updates its
// accumulator once per word. fixed_value is zero unless status is ok (0); 1
// means malformed text or a whole part beyond 2^63-1, and 2 means the scaled
// value exceeds 2^63-1.
// Depends on dtfe4_pkg, dtfe4_front, dtfe4_queue, dtfe4_parse, dtfe4_finish.
`default_nettype none

module decimal_text_to_fixed_e4_top
    import dtfe4_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_character,
    input  wire logic          s_last_char,
    input  wire logic          s_no_character,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic signed [63:0] m_fixed_value,
    output logic [1:0]         m_status
);

    logic   f_valid;
    logic   f_ready;
    token_t f_tok;
    logic   q_valid;
    logic   q_ready;
    token_t q_tok;
    logic   fin_valid;
    logic   fin_ready;
    fin_t   fin;

    // Character classification.
    dtfe4_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_character    (s_character),
        .s_last_char    (s_last_char),
        .s_no_character (s_no_character),
        .tok_valid      (f_valid),
        .tok_ready      (f_ready),
        .tok            (f_tok)
    );

    // Decoupling queue.
    dtfe4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_tok    (f_tok),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_tok   (q_tok)
    );

    // Grammar and digit accumulation.
    dtfe4_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (q_valid),
        .tok_ready (q_ready),
        .tok       (q_tok),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    // Padding, sign and result word.
    dtfe4_finish u_finish (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fin_valid     (fin_valid),
        .fin_ready     (fin_ready),
        .fin           (fin),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fixed_value (m_fixed_value),
        .m_status      (m_status)
    );

endmodule

`default_nettype wire

@@ rtl/dtfe4_port_chk.sv @@
// Port-level assertions for the decimal text parser, bound to the top level.
// Depends on dtfe4_pkg and decimal_text_to_fixed_e4_top_defines.svh.
`default_nettype none
`include "decimal_text_to_fixed_e4_top_defines.svh"

module dtfe4_port_chk
    import dtfe4_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [63:0] m_fixed_value,
    input wire logic [1:0]         m_status
);

    localparam logic [63:0] MIN_VALUE = 64'h8000_0000_0000_0000;

    // A stalled result word holds its value.
    `DTFE4_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_fixed_value) && $stable(m_status), "stalled result word changed")

    // Only the three defined status codes appear.
    `DTFE4_ASSERT_SAME(a_status_code, aclk, aresetn, m_valid, m_status == ST_OK || m_status == ST_MALFORMED || m_status == ST_OVERFLOW, "undefined status code")

    // A failed text carries a zero value.
    `DTFE4_ASSERT_SAME(a_zero_on_error, aclk, aresetn, m_valid && m_status != ST_OK, m_fixed_value == '0, "nonzero value on error status")

    // A good value never reaches the most negative code.
    `DTFE4_ASSERT_SAME(a_range, aclk, aresetn, m_valid && m_status == ST_OK, m_fixed_value != MIN_VALUE, "value out of range on ok status")

endmodule

bind decimal_text_to_fixed_e4_top dtfe4_port_chk u_port_chk (.*);

`default_nettype wire
